// ----- hw/rtl/sawarq_pkg.sv -----
// Shared types and constants for the stop-and-wait ARQ receiver.
// Used by sawarq_decide and stop_and_wait_arq_receiver; no dependencies.
`timescale 1ns / 1ps

package sawarq_pkg;

	localparam int SEQ_BITS = 32;
	localparam int TMO_BITS = 16;
	localparam int CFG_BITS = 2;

	localparam logic [TMO_BITS-1:0] MIN_TIMEOUT_RST  = TMO_BITS'(100);
	localparam logic [TMO_BITS-1:0] MAX_TIMEOUT_RST  = TMO_BITS'(5000);
	localparam logic [TMO_BITS-1:0] INIT_TIMEOUT_RST = TMO_BITS'(500);

	typedef enum logic [1:0] {
		OP_SEGMENT = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		T_DATA   = 3'd0,
		T_ACK    = 3'd1,
		T_NAK    = 3'd2,
		T_PING   = 3'd3,
		T_PONG   = 3'd4,
		T_FIN    = 3'd5,
		T_FINACK = 3'd6,
		T_ACKFIN = 3'd7
	} seg_type_t;

	typedef enum logic [CFG_BITS-1:0] {
		REG_MIN_TIMEOUT  = 2'd0,
		REG_MAX_TIMEOUT  = 2'd1,
		REG_INIT_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                 op;
		seg_type_t           seg_type;
		logic                seg_valid;
		logic [31:0]         seq_number;
		logic [31:0]         ack_number;
		logic                buffer_room;
	} item_t;

	typedef struct packed {
		logic                link_up;
		logic [SEQ_BITS-1:0] last_acc;
		logic [SEQ_BITS-1:0] oldest_unacked;
		logic [TMO_BITS-1:0] timeout;
	} state_t;

	typedef struct packed {
		logic [TMO_BITS-1:0] min_timeout;
		logic [TMO_BITS-1:0] max_timeout;
		logic [TMO_BITS-1:0] init_timeout;
	} cfg_t;

	typedef struct packed {
		logic                send_valid;
		seg_type_t           send_type;
		logic [31:0]         send_number;
		logic                deliver_data;
		logic                refused;
		logic                window_advanced;
		logic                nak_seen;
		logic                pong_seen;
		logic                finack_seen;
		logic                connected;
		logic [TMO_BITS-1:0] timeout_ms;
		logic [31:0]         next_unacked;
	} result_t;

endpackage

// ----- hw/rtl/stop_and_wait_arq_receiver.sv -----
// Top level of the stop-and-wait ARQ receiver: input register, link state,
// configuration registers and result register. Depends on sawarq_pkg, sawarq_decide.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per segment,
//   response timeout or restart. Output channel (out_valid/out_ready) returns
//   exactly one result transaction per input transaction, in order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   min, max and initial timeout; it is always ready. The user must see that it
//   is written while idle; the block does not enforce this. The decision stage
//   works on the input register and its result goes into the result register.
//   Throughput: one transaction per cycle while out_ready does not stall the
//   result, set by the single decision stage between the input register and the
//   result register; link state updates at the same edge the result is registered.
//   Reset: link down, sequence counters zero, timeout 500 ms, bounds 100 and
//   5000 ms. Nothing is pending after reset.
//   Stall: when out_ready is low the result holds; one more transaction is
//   taken into the input register if it is empty, then in_ready drops until the result drains.

module stop_and_wait_arq_receiver import sawarq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [2:0]          seg_type,
	input  logic                seg_valid,
	input  logic [31:0]         seq_number,
	input  logic [31:0]         ack_number,
	input  logic                buffer_room,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                send_valid,
	output logic [2:0]          send_type,
	output logic [31:0]         send_number,
	output logic                deliver_data,
	output logic                refused,
	output logic                window_advanced,
	output logic                nak_seen,
	output logic                pong_seen,
	output logic                finack_seen,
	output logic                connected,
	output logic [TMO_BITS-1:0] timeout_ms,
	output logic [31:0]         next_unacked,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] cfg_index,
	input  logic [TMO_BITS-1:0] cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	cfg_t    cfg_q;
	state_t  state_next;
	result_t res_next;
	logic    adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	sawarq_decide u_decide (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg_q),
		.state_next (state_next),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{op: op_t'(op), seg_type: seg_type_t'(seg_type),
				seg_valid: seg_valid, seq_number: seq_number,
				ack_number: ack_number, buffer_room: buffer_room};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{link_up: 1'b0, last_acc: '0, oldest_unacked: '0,
				timeout: INIT_TIMEOUT_RST};
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{min_timeout: MIN_TIMEOUT_RST, max_timeout: MAX_TIMEOUT_RST,
				init_timeout: INIT_TIMEOUT_RST};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_TIMEOUT:  cfg_q.min_timeout  <= cfg_data;
				REG_MAX_TIMEOUT:  cfg_q.max_timeout  <= cfg_data;
				REG_INIT_TIMEOUT: cfg_q.init_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid       = valid_s2;
	assign send_valid      = res_s2.send_valid;
	assign send_type       = res_s2.send_type;
	assign send_number     = res_s2.send_number;
	assign deliver_data    = res_s2.deliver_data;
	assign refused         = res_s2.refused;
	assign window_advanced = res_s2.window_advanced;
	assign nak_seen        = res_s2.nak_seen;
	assign pong_seen       = res_s2.pong_seen;
	assign finack_seen     = res_s2.finack_seen;
	assign connected       = res_s2.connected;
	assign timeout_ms      = res_s2.timeout_ms;
	assign next_unacked    = res_s2.next_unacked;

	a_send_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.send_valid |-> res_s2.connected)
		else $error("reply issued while link down");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.send_valid |-> res_s2.send_type == T_DATA
			&& res_s2.send_number == 32'd0)
		else $error("reply fields not cleared without reply");

	a_deliver_acks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.deliver_data |-> res_s2.send_valid
			&& res_s2.send_type == T_ACK
			&& 32'(state_q.last_acc) == res_s2.send_number)
		else $error("delivered data not acked or counter not updated");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a blocked result");

endmodule

// ----- hw/rtl/sawarq_decide.sv -----
// Per-item decision logic: next link state and result for one transaction.
// Purely combinational; depends on sawarq_pkg.
`timescale 1ns / 1ps

module sawarq_decide import sawarq_pkg::*; (
	input  item_t   item,
	input  state_t  state,
	input  cfg_t    cfg,
	output state_t  state_next,
	output result_t res
);

	logic [SEQ_BITS-1:0] seq;
	logic [SEQ_BITS-1:0] ack;
	logic [TMO_BITS:0]   grow_sum;
	logic [TMO_BITS-1:0] grow_val;
	logic [TMO_BITS-1:0] shrink_diff;
	logic [TMO_BITS-1:0] shrink_val;
	logic [SEQ_BITS-1:0] snum;

	assign seq = SEQ_BITS'(item.seq_number);
	assign ack = SEQ_BITS'(item.ack_number);

	assign grow_sum = {1'b0, state.timeout} + {2'b00, state.timeout[TMO_BITS-1:1]};
	assign grow_val = (grow_sum > {1'b0, cfg.max_timeout}) ? cfg.max_timeout
		: grow_sum[TMO_BITS-1:0];
	assign shrink_diff = state.timeout - {2'b00, state.timeout[TMO_BITS-1:2]};
	assign shrink_val = (shrink_diff < cfg.min_timeout) ? cfg.min_timeout : shrink_diff;

	always_comb begin
		state_next          = state;
		snum                = '0;
		res                 = '0;
		res.send_type       = T_DATA;
		case (item.op)
			OP_TIMEOUT: begin
				state_next.timeout = grow_val;
			end
			OP_RESTART: begin
				state_next.link_up = 1'b1;
				state_next.timeout = cfg.init_timeout;
			end
			OP_SEGMENT: begin
				if (state.link_up) begin
					if (!item.seg_valid) begin
						if (item.seg_type == T_DATA) begin
							res.send_valid = 1'b1;
							res.send_type  = T_NAK;
							snum           = seq;
						end
					end else begin
						state_next.timeout = shrink_val;
						case (item.seg_type)
							T_DATA: begin
								if (!item.buffer_room) begin
									res.refused = 1'b1;
								end else if (state.last_acc + SEQ_BITS'(1) == seq) begin
									res.send_valid     = 1'b1;
									res.send_type      = T_ACK;
									snum               = seq;
									state_next.last_acc = seq;
									res.deliver_data   = 1'b1;
								end else if (state.last_acc == seq) begin
									res.send_valid = 1'b1;
									res.send_type  = T_ACK;
									snum           = seq;
								end
							end
							T_ACK: begin
								if (ack >= state.oldest_unacked) begin
									state_next.oldest_unacked = ack + SEQ_BITS'(1);
									res.window_advanced       = 1'b1;
								end
							end
							T_NAK:    res.nak_seen = (ack == state.oldest_unacked);
							T_PING: begin
								res.send_valid = 1'b1;
								res.send_type  = T_PONG;
							end
							T_PONG:   res.pong_seen = 1'b1;
							T_FIN: begin
								res.send_valid = 1'b1;
								res.send_type  = T_FINACK;
							end
							T_FINACK: res.finack_seen = 1'b1;
							default:  state_next.link_up = 1'b0;
						endcase
					end
				end
			end
			default: ;
		endcase
		res.send_number  = 32'(snum);
		res.connected    = state_next.link_up;
		res.timeout_ms   = state_next.timeout;
		res.next_unacked = 32'(state_next.oldest_unacked);
	end

endmodule
